// ----- src/bhpq_pkg.sv -----
// Shared types, constants and compare function of the binary heap priority queue.
package bhpq_pkg;

	localparam int CAPACITY = 64;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int CHILD_W  = ADDR_W + 2;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_REMOVE = 1'b1;

	typedef struct packed {
		logic              kind;
		logic signed [31:0] value;
		logic [5:0]        position;
	} bhpq_in_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] removed_value;
		logic signed [31:0] top_value;
		logic [6:0]         count;
	} bhpq_out_t;

	typedef struct packed {
		logic accept;
		logic rm_load;
		logic up_step;
		logic up_end;
		logic dn_step;
		logic rd_top;
		logic out_load;
	} bhpq_cmd_t;

	typedef struct packed {
		logic acc_err;
		logic acc_root;
		logic acc_rm;
		logic kind_rm;
		logic rm_last;
		logic pos_zero;
		logic up_move;
		logic up_root;
		logic dn_move;
		logic out_free;
	} bhpq_stat_t;

	// True when a belongs above b: larger for a max heap, smaller for a min heap.
	function automatic logic better(logic signed [31:0] a, logic signed [31:0] b,
			logic min_mode);
		better = min_mode ? (a < b) : (a > b);
	endfunction

endpackage

// ----- src/binary_heap_priority_queue.sv -----
// Top level of the binary heap priority queue: controller plus datapath.
// A refused request or an insert into an empty heap goes straight to the top read; any other insert
// then climbs as far as needed; a remove of the last entry needs no sift, one at the root only sinks,
// and one anywhere else first climbs, then sinks, as far as needed.
// The sift loop moves one level per cycle over the heap memory's two registered read ports
// and single write port.
// One request is in work at a time; the next is taken once the result sits in the output register.
// Reset empties the heap and selects max mode; the memory contents are not cleared.
module binary_heap_priority_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  bhpq_pkg::bhpq_in_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output bhpq_pkg::bhpq_out_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_data
);

	bhpq_pkg::bhpq_cmd_t  cmd;
	bhpq_pkg::bhpq_stat_t stat;

	// The mode register can always take a write; the user must write it only while the block is idle (not enforced here).
	assign cfg_ready = 1'b1;

	// The controller walks each request through load, sift-up, sift-down and top read.
	bhpq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// The datapath holds the heap memory, the moving value, the hole index and the result.
	bhpq_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_write (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.out_data  (out_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule

// ----- src/bhpq_ctrl.sv -----
// Controller state machine of the binary heap priority queue.
module bhpq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  bhpq_pkg::bhpq_stat_t stat,
	output bhpq_pkg::bhpq_cmd_t  cmd
);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_RMLD  = 7'b0000010,
		S_UP    = 7'b0000100,
		S_UPEND = 7'b0001000,
		S_DN    = 7'b0010000,
		S_FIN   = 7'b0100000,
		S_TOP   = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (stat.acc_err || stat.acc_root) begin
						state_d = S_FIN;
					end else if (stat.acc_rm) begin
						state_d = S_RMLD;
					end else begin
						state_d = S_UP;
					end
				end
			end
			S_RMLD: begin
				cmd.rm_load = 1'b1;
				if (stat.rm_last) begin
					state_d = S_FIN;
				end else if (stat.pos_zero) begin
					state_d = S_DN;
				end else begin
					state_d = S_UP;
				end
			end
			S_UP: begin
				cmd.up_step = 1'b1;
				if (stat.up_move) begin
					state_d = stat.up_root ? S_UPEND : S_UP;
				end else begin
					state_d = stat.kind_rm ? S_DN : S_FIN;
				end
			end
			S_UPEND: begin
				cmd.up_end = 1'b1;
				state_d    = stat.kind_rm ? S_DN : S_FIN;
			end
			S_DN: begin
				cmd.dn_step = 1'b1;
				state_d     = stat.dn_move ? S_DN : S_FIN;
			end
			S_FIN: begin
				cmd.rd_top = 1'b1;
				state_d    = S_TOP;
			end
			S_TOP: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- src/bhpq_dpath.sv -----
// Datapath of the binary heap priority queue: heap memory, hole registers and result register.
module bhpq_dpath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bhpq_pkg::bhpq_in_t   in_data,
	input  logic                 cfg_write,
	input  logic                 cfg_data,
	output bhpq_pkg::bhpq_out_t  out_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	input  bhpq_pkg::bhpq_cmd_t  cmd,
	output bhpq_pkg::bhpq_stat_t stat
);

	localparam int AW = bhpq_pkg::ADDR_W;
	localparam int CW = bhpq_pkg::CNT_W;
	localparam int HW = bhpq_pkg::CHILD_W;

	logic signed [31:0] mem [bhpq_pkg::CAPACITY];

	logic [CW-1:0]      count_q;
	logic               min_mode_q;
	logic signed [31:0] x_q;
	logic signed [31:0] first_q;
	logic               moved_q;
	logic [AW-1:0]      k_q;
	logic [AW-1:0]      pos_q;
	logic               kind_q;
	logic [1:0]         status_q;
	logic signed [31:0] removed_q;
	logic signed [31:0] rd0_q, rd1_q;
	bhpq_pkg::bhpq_out_t out_q;
	logic               out_valid_q;

	// Memory port controls.
	logic               we;
	logic [AW-1:0]      waddr;
	logic signed [31:0] wdata;
	logic               rd_en;
	logic [AW-1:0]      raddr0, raddr1;

	// Index arithmetic.
	logic [CW-1:0]      pos_in_ext, pos_ext;
	logic [AW-1:0]      cnt_addr, last_addr, par_cnt, par_k, par_pos, par_par;
	logic [HW-1:0]      l_k, r_k, l_pos, r_pos, cnt_ext;
	logic               ins_full, rm_bad;
	logic               up_move, dn_bl, dn_br, lv, rv;
	logic signed [31:0] dn_best;
	logic [HW-1:0]      dn_child;
	logic signed [31:0] dn_cval;
	logic [HW-1:0]      l_child, r_child;

	assign pos_in_ext = CW'(in_data.position);
	assign pos_ext    = CW'(pos_q);
	assign cnt_addr   = count_q[AW-1:0];
	assign last_addr  = AW'(count_q - CW'(1));
	assign par_cnt    = AW'((count_q - CW'(1)) >> 1);
	assign par_k      = (k_q - AW'(1)) >> 1;
	assign par_pos    = (pos_q - AW'(1)) >> 1;
	assign par_par    = (par_k - AW'(1)) >> 1;
	assign l_k        = {1'b0, k_q, 1'b1};
	assign r_k        = l_k + HW'(1);
	assign l_pos      = {1'b0, pos_q, 1'b1};
	assign r_pos      = l_pos + HW'(1);
	assign cnt_ext    = HW'(count_q);

	assign ins_full = (count_q == CW'(bhpq_pkg::CAPACITY));
	assign rm_bad   = (pos_in_ext >= count_q);

	assign up_move  = bhpq_pkg::better(x_q, rd0_q, min_mode_q);

	// Sift-down choice: the right child is tested against the best so far.
	assign lv       = (l_k < cnt_ext);
	assign rv       = (r_k < cnt_ext);
	assign dn_bl    = lv && bhpq_pkg::better(rd0_q, x_q, min_mode_q);
	assign dn_best  = dn_bl ? rd0_q : x_q;
	assign dn_br    = rv && bhpq_pkg::better(rd1_q, dn_best, min_mode_q);
	assign dn_child = dn_br ? r_k : l_k;
	assign dn_cval  = dn_br ? rd1_q : rd0_q;
	assign l_child  = {dn_child[HW-2:0], 1'b1};
	assign r_child  = l_child + HW'(1);

	assign stat.acc_err  = (in_data.kind == bhpq_pkg::KIND_INSERT) ? ins_full : rm_bad;
	assign stat.acc_root = (in_data.kind == bhpq_pkg::KIND_INSERT) && (count_q == '0);
	assign stat.acc_rm   = (in_data.kind == bhpq_pkg::KIND_REMOVE);
	assign stat.kind_rm  = (kind_q == bhpq_pkg::KIND_REMOVE);
	assign stat.rm_last  = (pos_ext == count_q - CW'(1));
	assign stat.pos_zero = (pos_q == '0);
	assign stat.up_move  = up_move;
	assign stat.up_root  = (par_k == '0);
	assign stat.dn_move  = dn_bl || dn_br;
	assign stat.out_free = !out_valid_q || !out_stall;

	always_comb begin
		we     = 1'b0;
		waddr  = k_q;
		wdata  = x_q;
		rd_en  = 1'b0;
		raddr0 = '0;
		raddr1 = '0;
		if (cmd.accept) begin
			if (in_data.kind == bhpq_pkg::KIND_INSERT) begin
				if (!ins_full && count_q == '0) begin
					we    = 1'b1;
					waddr = '0;
					wdata = in_data.value;
				end else if (!ins_full) begin
					rd_en  = 1'b1;
					raddr0 = par_cnt;
				end
			end else if (!rm_bad) begin
				rd_en  = 1'b1;
				raddr0 = AW'(in_data.position);
				raddr1 = last_addr;
			end
		end
		if (cmd.rm_load && !stat.rm_last) begin
			rd_en = 1'b1;
			if (pos_q == '0) begin
				raddr0 = l_pos[AW-1:0];
				raddr1 = r_pos[AW-1:0];
			end else begin
				raddr0 = par_pos;
			end
		end
		if ((cmd.up_step && up_move)) begin
			we    = 1'b1;
			wdata = rd0_q;
			if (par_k != '0) begin
				rd_en  = 1'b1;
				raddr0 = par_par;
			end
		end
		if ((cmd.up_step && !up_move) || cmd.up_end) begin
			// Settle the moving value; for a remove, also start the downward pass at the hole.
			we = 1'b1;
			if (kind_q == bhpq_pkg::KIND_REMOVE) begin
				rd_en  = 1'b1;
				raddr0 = l_pos[AW-1:0];
				raddr1 = r_pos[AW-1:0];
			end
		end
		if (cmd.dn_step) begin
			we = 1'b1;
			if (dn_bl || dn_br) begin
				wdata  = dn_cval;
				rd_en  = 1'b1;
				raddr0 = l_child[AW-1:0];
				raddr1 = r_child[AW-1:0];
			end
		end
		if (cmd.rd_top) begin
			rd_en  = 1'b1;
			raddr0 = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (rd_en) begin
			rd0_q <= mem[raddr0];
			rd1_q <= mem[raddr1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			min_mode_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				min_mode_q <= cfg_data;
			end
			if (cmd.accept && in_data.kind == bhpq_pkg::KIND_INSERT && !ins_full) begin
				count_q <= count_q + CW'(1);
			end
			if (cmd.rm_load) begin
				count_q <= count_q - CW'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			kind_q    <= in_data.kind;
			pos_q     <= AW'(in_data.position);
			moved_q   <= 1'b0;
			removed_q <= '0;
			x_q       <= in_data.value;
			k_q       <= cnt_addr;
			if (in_data.kind == bhpq_pkg::KIND_INSERT) begin
				status_q <= ins_full ? bhpq_pkg::ST_FULL : bhpq_pkg::ST_DONE;
			end else begin
				status_q <= rm_bad ? bhpq_pkg::ST_RANGE : bhpq_pkg::ST_DONE;
			end
		end
		if (cmd.rm_load) begin
			removed_q <= rd0_q;
			x_q       <= rd1_q;
			k_q       <= pos_q;
		end
		if (cmd.up_step && up_move) begin
			k_q <= par_k;
			if (!moved_q) begin
				first_q <= rd0_q;
				moved_q <= 1'b1;
			end
		end
		if (((cmd.up_step && !up_move) || cmd.up_end) && kind_q == bhpq_pkg::KIND_REMOVE) begin
			// After upward moves the entry left at the hole is the first parent moved.
			x_q <= moved_q ? first_q : x_q;
			k_q <= pos_q;
		end
		if (cmd.dn_step && (dn_bl || dn_br)) begin
			k_q <= dn_child[AW-1:0];
		end
		if (cmd.out_load) begin
			out_q.status        <= status_q;
			out_q.removed_value <= removed_q;
			out_q.top_value     <= (count_q != '0) ? rd0_q : 32'sd0;
			out_q.count         <= 7'(count_q);
		end
	end

	assign out_data  = out_q;
	assign out_valid = out_valid_q;

endmodule
